[hw/rtl/mft_pkg.sv]
`timescale 1ns / 1ps

package mft_pkg;

   localparam int MAC_W          = 48;
   localparam int PORT_OUT_W     = 10;
   localparam int COUNT_OUT_W    = 7;
   localparam int DEF_TABLE_DEPTH = 64;
   localparam int DEF_PORT_BITS  = 10;
   localparam int DEF_ENTRY_W    = MAC_W + DEF_PORT_BITS + 1;

   // Action codes carried in a request.
   localparam logic [2:0] ACT_CLEAR    = 3'd0;
   localparam logic [2:0] ACT_INSERT   = 3'd1;
   localparam logic [2:0] ACT_LOOKUP   = 3'd2;
   localparam logic [2:0] ACT_LIST_PRT = 3'd3;
   localparam logic [2:0] ACT_LIST_MAC = 3'd4;

   // Status codes carried in a response.
   localparam logic [1:0] STS_OK        = 2'd0;
   localparam logic [1:0] STS_FULL      = 2'd1;
   localparam logic [1:0] STS_DUPLICATE = 2'd2;
   localparam logic [1:0] STS_NOT_FOUND = 2'd3;

   typedef struct packed {
      logic [2:0]       action;
      logic [MAC_W-1:0] station_mac;
      logic [9:0]       port_no;
      logic             local_entry;
   } req_type;

   typedef struct packed {
      logic [1:0]             status;
      logic [PORT_OUT_W-1:0]  port_out;
      logic [MAC_W-1:0]       mac_out;
      logic [COUNT_OUT_W-1:0] match_count;
      logic                   last;
   } rsp_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DUP,
      ST_LOOK,
      ST_LIST,
      ST_DONE
   } state_type;

endpackage

[hw/rtl/mft_entry_ram.sv]
`timescale 1ns / 1ps

module mft_entry_ram
   import mft_pkg::*;
#(
   parameter int DEPTH = DEF_TABLE_DEPTH,
   parameter int WIDTH = DEF_ENTRY_W
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      rd_data <= mem[rd_addr];
   end

endmodule

[hw/rtl/mac_forwarding_table.sv]
`timescale 1ns / 1ps

// Layer-2 forwarding table held as a packed list of entries in one RAM.
// Requests arrive on the req_ channel (valid/ready) as one transaction each,
// carrying an action, a MAC address, a port and a local flag. Results leave on
// the rsp_ channel (valid/ready); every request gives exactly one response
// transaction, except a list action, which gives one per matching entry with
// last set on the final one, or a single not-found one if none match, and an
// undefined action, which gives none. The block handles one request at a time
// and is not ready while working. The table is walked one stored entry per
// clock cycle through the single read port of the entry RAM, except while a
// list walk is held by a stalled receiver. A new request is taken only after
// the last response has been loaded into the output register.
// Reset empties the table at once by zeroing the entry count; the RAM itself
// is never cleared, since only entries below the count are ever used.
// When the receiver stalls, the walk holds on the entry that needs to emit
// and re-reads it each cycle, so no response is lost or repeated.
module mac_forwarding_table
   import mft_pkg::*;
#(
   parameter int TABLE_DEPTH = DEF_TABLE_DEPTH,
   parameter int PORT_BITS   = DEF_PORT_BITS
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data
);

   localparam int AW      = $clog2(TABLE_DEPTH);
   localparam int CW      = $clog2(TABLE_DEPTH + 1);
   localparam int ENTRY_W = MAC_W + PORT_BITS + 1;

   // Control state.
   state_type            state_ff, state_in;
   logic [CW-1:0]        idx_ff, idx_in;
   logic [CW-1:0]        count_ff, count_in;
   logic                 pend_valid_ff, pend_valid_in;
   logic                 rsp_valid_ff, rsp_valid_in;

   // Payload held for the request in progress.
   logic [2:0]           item_act_ff, item_act_in;
   logic [MAC_W-1:0]     item_mac_ff, item_mac_in;
   logic [PORT_BITS-1:0] item_port_ff, item_port_in;
   logic                 item_local_ff, item_local_in;
   logic [PORT_BITS-1:0] key_port_ff, key_port_in;
   logic [MAC_W-1:0]     pend_mac_ff, pend_mac_in;
   logic [CW-1:0]        cnt_ff, cnt_in;
   rsp_type              rslt_ff, rslt_in;
   rsp_type              rsp_data_ff, rsp_data_in;

   // Entry RAM access.
   logic                 wr_en;
   logic [AW-1:0]        wr_addr;
   logic [ENTRY_W-1:0]   wr_data;
   logic [ENTRY_W-1:0]   rd_data;

   logic [MAC_W-1:0]     e_mac;
   logic [PORT_BITS-1:0] e_port;
   logic                 e_local;
   logic                 scan_end;
   logic                 out_free;

   // The read address follows the next walk index, so the registered read data
   // always belongs to the entry at idx_ff. Holding the index re-reads it.
   mft_entry_ram #(
      .DEPTH (TABLE_DEPTH),
      .WIDTH (ENTRY_W)
   ) u_entry_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (idx_in[AW-1:0]),
      .rd_data (rd_data)
   );

   assign e_mac    = rd_data[MAC_W-1:0];
   assign e_port   = rd_data[MAC_W +: PORT_BITS];
   assign e_local  = rd_data[ENTRY_W-1];
   assign scan_end = (idx_ff == count_ff);
   assign out_free = !rsp_valid_ff || rsp_ready;

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   always_comb begin
      state_in      = state_ff;
      idx_in        = idx_ff;
      count_in      = count_ff;
      pend_valid_in = pend_valid_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      item_act_in   = item_act_ff;
      item_mac_in   = item_mac_ff;
      item_port_in  = item_port_ff;
      item_local_in = item_local_ff;
      key_port_in   = key_port_ff;
      pend_mac_in   = pend_mac_ff;
      cnt_in        = cnt_ff;
      rslt_in       = rslt_ff;
      rsp_data_in   = rsp_data_ff;
      wr_en         = 1'b0;
      wr_addr       = count_ff[AW-1:0];
      wr_data       = {item_local_ff, item_port_ff, item_mac_ff};

      case (state_ff)
         ST_IDLE: begin
            idx_in = '0;
            if (req_valid) begin
               item_act_in   = req_data.action;
               item_mac_in   = req_data.station_mac;
               item_port_in  = PORT_BITS'(req_data.port_no);
               item_local_in = req_data.local_entry;
               key_port_in   = PORT_BITS'(req_data.port_no);
               pend_valid_in = 1'b0;
               cnt_in        = '0;
               rslt_in       = '{status: STS_OK, port_out: '0, mac_out: '0,
                                 match_count: '0, last: 1'b1};
               case (req_data.action)
                  ACT_CLEAR: begin
                     count_in = '0;
                     state_in = ST_DONE;
                  end
                  ACT_INSERT: begin
                     if (count_ff == CW'(TABLE_DEPTH)) begin
                        rslt_in.status   = STS_FULL;
                        rslt_in.port_out = PORT_OUT_W'(PORT_BITS'(req_data.port_no));
                        state_in         = ST_DONE;
                     end else begin
                        state_in = ST_DUP;
                     end
                  end
                  ACT_LOOKUP, ACT_LIST_MAC: begin
                     state_in = ST_LOOK;
                  end
                  ACT_LIST_PRT: begin
                     state_in = ST_LIST;
                  end
                  default: begin
                     // Undefined actions are taken and dropped without a response.
                     state_in = ST_IDLE;
                  end
               endcase
            end
         end

         ST_DUP: begin
            rslt_in.port_out = PORT_OUT_W'(item_port_ff);
            if (scan_end) begin
               wr_en    = 1'b1;
               count_in = count_ff + 1'b1;
               state_in = ST_DONE;
            end else if (e_mac == item_mac_ff && e_port == item_port_ff) begin
               rslt_in.status = STS_DUPLICATE;
               state_in       = ST_DONE;
            end else begin
               idx_in = idx_ff + 1'b1;
            end
         end

         ST_LOOK: begin
            if (scan_end) begin
               rslt_in.status   = STS_NOT_FOUND;
               rslt_in.port_out = '0;
               state_in         = ST_DONE;
            end else if (e_mac == item_mac_ff && e_local) begin
               if (item_act_ff == ACT_LOOKUP) begin
                  rslt_in.status   = STS_OK;
                  rslt_in.port_out = PORT_OUT_W'(e_port);
                  state_in         = ST_DONE;
               end else begin
                  // List-by-MAC: the local port found becomes the key of a
                  // fresh walk from the head of the table.
                  key_port_in = e_port;
                  idx_in      = '0;
                  state_in    = ST_LIST;
               end
            end else begin
               idx_in = idx_ff + 1'b1;
            end
         end

         ST_LIST: begin
            // A match is held back until the next one, or the end of the
            // table, tells whether it is the last one.
            if (scan_end) begin
               if (out_free) begin
                  rsp_valid_in = 1'b1;
                  if (pend_valid_ff) begin
                     rsp_data_in = '{status: STS_OK,
                                     port_out: PORT_OUT_W'(key_port_ff),
                                     mac_out: pend_mac_ff,
                                     match_count: COUNT_OUT_W'(cnt_ff),
                                     last: 1'b1};
                  end else begin
                     rsp_data_in = '{status: STS_NOT_FOUND,
                                     port_out: PORT_OUT_W'(key_port_ff),
                                     mac_out: '0, match_count: '0, last: 1'b1};
                  end
                  pend_valid_in = 1'b0;
                  state_in      = ST_IDLE;
               end
            end else if (e_port == key_port_ff && !e_local) begin
               if (!pend_valid_ff) begin
                  pend_valid_in = 1'b1;
                  pend_mac_in   = e_mac;
                  cnt_in        = cnt_ff + 1'b1;
                  idx_in        = idx_ff + 1'b1;
               end else if (out_free) begin
                  rsp_valid_in = 1'b1;
                  rsp_data_in  = '{status: STS_OK,
                                   port_out: PORT_OUT_W'(key_port_ff),
                                   mac_out: pend_mac_ff,
                                   match_count: COUNT_OUT_W'(cnt_ff),
                                   last: 1'b0};
                  pend_mac_in  = e_mac;
                  cnt_in       = cnt_ff + 1'b1;
                  idx_in       = idx_ff + 1'b1;
               end
            end else begin
               idx_in = idx_ff + 1'b1;
            end
         end

         ST_DONE: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = rslt_ff;
               state_in     = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         idx_ff        <= '0;
         count_ff      <= '0;
         pend_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         idx_ff        <= idx_in;
         count_ff      <= count_in;
         pend_valid_ff <= pend_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      item_act_ff   <= item_act_in;
      item_mac_ff   <= item_mac_in;
      item_port_ff  <= item_port_in;
      item_local_ff <= item_local_in;
      key_port_ff   <= key_port_in;
      pend_mac_ff   <= pend_mac_in;
      cnt_ff        <= cnt_in;
      rslt_ff       <= rslt_in;
      rsp_data_ff   <= rsp_data_in;
   end

endmodule

[dv/mac_forwarding_table_tb.sv]
`timescale 1ns / 1ps

module mac_forwarding_table_tb;
   import mft_pkg::*;

   localparam int DEPTH          = DEF_TABLE_DEPTH;
   // Requests in the random part; the directed part and the table fill add
   // roughly another ninety.
   localparam int REQUEST_TARGET = 60;
   // Quiet window after the last expected response, longer than a double walk
   // of a full table, so that a stray response would still be seen.
   localparam int SETTLE_CYCLES  = 2 * DEF_TABLE_DEPTH + 16;
   // Far above the slowest legal run: every list answering with a full table
   // while the receiver stalls for its longest gap on each response.
   localparam int CYCLE_LIMIT    = 3000000;

   // Shadow copy of the forwarding table. Each accepted request transaction is
   // applied here and the response transactions it should cause are queued in
   // order; each response seen on the rsp_ channel is checked against the
   // oldest one still waiting.
   class fdb_shadow;
      logic [MAC_W-1:0]         ent_mac   [DEPTH];
      logic [DEF_PORT_BITS-1:0] ent_port  [DEPTH];
      bit                       ent_local [DEPTH];
      int unsigned              ent_count;
      rsp_type                  due_rsp   [$];
      int unsigned              mismatches;
      int unsigned              checked;
      int unsigned              longest_list;
      int unsigned              full_refusals;

      function new();
         ent_count     = 0;
         mismatches    = 0;
         checked       = 0;
         longest_list  = 0;
         full_refusals = 0;
      endfunction

      function void push_rsp(logic [1:0] status, logic [PORT_OUT_W-1:0] port,
                             logic [MAC_W-1:0] mac, int unsigned cnt, bit last);
         rsp_type r;
         r.status      = status;
         r.port_out    = port;
         r.mac_out     = mac;
         r.match_count = COUNT_OUT_W'(cnt);
         r.last        = last;
         due_rsp.push_back(r);
      endfunction

      // First local entry carrying this MAC wins.
      function bit find_local_port(input logic [MAC_W-1:0] mac,
                                   output logic [DEF_PORT_BITS-1:0] port);
         port = '0;
         for (int i = 0; i < ent_count; i++) begin
            if (ent_local[i] && ent_mac[i] == mac) begin
               port = ent_port[i];
               return 1'b1;
            end
         end
         return 1'b0;
      endfunction

      function void list_remote(input logic [DEF_PORT_BITS-1:0] port);
         int unsigned total;
         int unsigned hits;
         total = 0;
         hits  = 0;
         for (int i = 0; i < ent_count; i++)
            if (!ent_local[i] && ent_port[i] == port) total++;
         if (total == 0) begin
            push_rsp(STS_NOT_FOUND, port, '0, 0, 1'b1);
         end else begin
            for (int i = 0; i < ent_count; i++) begin
               if (!ent_local[i] && ent_port[i] == port) begin
                  hits++;
                  push_rsp(STS_OK, port, ent_mac[i], hits, hits == total);
               end
            end
         end
         if (total > longest_list) longest_list = total;
      endfunction

      function void apply_request(input req_type rq);
         logic [DEF_PORT_BITS-1:0] port;
         bit                       dup;
         port = rq.port_no;
         dup  = 1'b0;
         case (rq.action)
            ACT_CLEAR: begin
               ent_count = 0;
               push_rsp(STS_OK, '0, '0, 0, 1'b1);
            end
            ACT_INSERT: begin
               // Fullness is judged before the duplicate search.
               if (ent_count >= DEPTH) begin
                  full_refusals++;
                  push_rsp(STS_FULL, port, '0, 0, 1'b1);
               end else begin
                  for (int i = 0; i < ent_count; i++)
                     if (ent_mac[i] == rq.station_mac && ent_port[i] == port) dup = 1'b1;
                  if (dup) begin
                     push_rsp(STS_DUPLICATE, port, '0, 0, 1'b1);
                  end else begin
                     ent_mac[ent_count]   = rq.station_mac;
                     ent_port[ent_count]  = port;
                     ent_local[ent_count] = rq.local_entry;
                     ent_count++;
                     push_rsp(STS_OK, port, '0, 0, 1'b1);
                  end
               end
            end
            ACT_LOOKUP: begin
               if (find_local_port(rq.station_mac, port)) push_rsp(STS_OK, port, '0, 0, 1'b1);
               else push_rsp(STS_NOT_FOUND, '0, '0, 0, 1'b1);
            end
            ACT_LIST_PRT: begin
               list_remote(port);
            end
            ACT_LIST_MAC: begin
               if (find_local_port(rq.station_mac, port)) list_remote(port);
               else push_rsp(STS_NOT_FOUND, '0, '0, 0, 1'b1);
            end
            default: begin
            end
         endcase
      endfunction

      function void check_response(input rsp_type got);
         rsp_type want;
         if (due_rsp.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display({"%0t: response transaction with none outstanding: ",
                         "status %0d port %0d mac %h count %0d last %0d"},
                        $time, got.status, got.port_out, got.mac_out,
                        got.match_count, got.last);
            return;
         end
         want = due_rsp.pop_front();
         checked++;
         if (got.status !== want.status || got.port_out !== want.port_out ||
             got.mac_out !== want.mac_out || got.match_count !== want.match_count ||
             got.last !== want.last) begin
            mismatches++;
            if (mismatches <= 10) begin
               $display("%0t: response mismatch", $time);
               $display("   expected status %0d port %0d mac %h count %0d last %0d",
                        want.status, want.port_out, want.mac_out,
                        want.match_count, want.last);
               $display("   actual   status %0d port %0d mac %h count %0d last %0d",
                        got.status, got.port_out, got.mac_out,
                        got.match_count, got.last);
            end
         end
      endfunction
   endclass

   logic    clock     = 1'b0;
   logic    reset     = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_ready;
   req_type req_data  = '0;
   logic    rsp_valid;
   logic    rsp_ready = 1'b0;
   rsp_type rsp_data;

   fdb_shadow   shadow;
   int unsigned requests_sent = 0;
   int unsigned ignored_sent  = 0;
   int unsigned cycle_count   = 0;
   // While set, neither side inserts gaps, giving stretches at full rate.
   bit          no_idle       = 1'b0;

   mac_forwarding_table dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Mostly back-to-back, sometimes a short pause, now and then a long one.
   function automatic int unsigned pick_gap();
      int unsigned roll;
      if (no_idle) return 0;
      roll = $urandom_range(0, 99);
      if (roll < 55) return 0;
      if (roll < 90) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   function automatic logic [MAC_W-1:0] rand_mac();
      logic [63:0] w;
      w = {$urandom(), $urandom()};
      return w[MAC_W-1:0];
   endfunction

   function automatic req_type make_req(logic [2:0] act, logic [MAC_W-1:0] mac,
                                        logic [9:0] port, bit loc);
      req_type rq;
      rq.action      = act;
      rq.station_mac = mac;
      rq.port_no     = port;
      rq.local_entry = loc;
      return rq;
   endfunction

   // Presents one request transaction and holds it until the block takes it.
   // The valid line is only dropped when a gap follows, so that back-to-back
   // transactions never see valid lowered and raised in the same time step.
   task automatic send_request(input req_type rq);
      int unsigned gap;
      req_valid <= 1'b1;
      req_data  <= rq;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      shadow.apply_request(rq);
      if (rq.action > ACT_LIST_MAC) ignored_sent++;
      else requests_sent++;
      gap = pick_gap();
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // Holds the sender back until every predicted response has been seen.
   // At least one edge passes, so a following request never shares a time
   // step with the lowering of valid.
   task automatic wait_drained();
      req_valid <= 1'b0;
      do @(posedge clock);
      while (shadow.due_rsp.size() != 0);
   endtask

   // Receiver: ready is raised for a random run of cycles, then dropped for a
   // random gap, independent of whether a response is on offer.
   initial begin
      int unsigned n;
      while (reset) @(posedge clock);
      forever begin
         n = pick_gap();
         if (n != 0) begin
            rsp_ready <= 1'b0;
            repeat (n) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         repeat ($urandom_range(1, 8)) @(posedge clock);
      end
   end

   // Values are taken as they stood just before the edge, the same values the
   // block itself sees, so the check does not depend on scheduling order.
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) shadow.check_response(rsp_data);
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("Timed out after %0d cycles with %0d responses outstanding",
                  cycle_count, shadow.due_rsp.size());
         $display("Verification failed");
         $finish;
      end
   end

   initial begin
      logic [MAC_W-1:0] mac_pool  [8];
      logic [9:0]       port_pool [4];
      logic [MAC_W-1:0] mac_a;
      logic [MAC_W-1:0] mac_b;
      logic [MAC_W-1:0] first_mac;
      int unsigned      roll;
      int unsigned      burst;
      int unsigned      start_count;
      shadow = new();

      mac_a = rand_mac();
      mac_b = rand_mac();
      mac_pool[0] = '0;
      mac_pool[1] = '1;
      mac_pool[2] = mac_a;
      mac_pool[3] = mac_b;
      for (int i = 4; i < 8; i++) mac_pool[i] = rand_mac();
      port_pool[0] = '0;
      port_pool[1] = '1;
      port_pool[2] = 10'($urandom_range(1, 1022));
      port_pool[3] = 10'($urandom_range(1, 1022));

      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // Directed part. The empty table first: every query misses and an empty
      // list still answers with a single not-found transaction.
      send_request(make_req(ACT_CLEAR,    '0, '0, 1'b0));
      send_request(make_req(ACT_LOOKUP,   '1, '0, 1'b0));
      send_request(make_req(ACT_LIST_PRT, '0, '0, 1'b0));
      send_request(make_req(ACT_LIST_MAC, '1, '1, 1'b1));
      // A local entry, then the same MAC and port as a remote one, which is a
      // duplicate whatever its local flag.
      send_request(make_req(ACT_INSERT, '1,    '1, 1'b1));
      send_request(make_req(ACT_INSERT, '1,    '1, 1'b0));
      send_request(make_req(ACT_INSERT, '0,    '0, 1'b0));
      send_request(make_req(ACT_INSERT, mac_a, '1, 1'b0));
      send_request(make_req(ACT_INSERT, mac_b, '1, 1'b0));
      // Same MAC on another port is allowed; a lookup must still return the
      // first local entry.
      send_request(make_req(ACT_INSERT, '1, 10'd5, 1'b1));
      send_request(make_req(ACT_LOOKUP, '1, '0, 1'b0));
      // A MAC held only as a remote entry is not found by a lookup.
      send_request(make_req(ACT_LOOKUP,   '0, '0, 1'b0));
      send_request(make_req(ACT_LIST_PRT, '0, '1, 1'b0));
      send_request(make_req(ACT_LIST_MAC, '1, '0, 1'b0));
      send_request(make_req(ACT_LIST_PRT, '0, '0, 1'b0));
      send_request(make_req(ACT_LIST_MAC, '0, '0, 1'b0));
      // A port holding only a local entry lists as empty.
      send_request(make_req(ACT_LIST_PRT, '0, 10'd5, 1'b0));
      // Undefined actions must be swallowed without a response.
      send_request(make_req(3'd5, '1, '1, 1'b1));
      send_request(make_req(3'd6, '0, '0, 1'b0));
      send_request(make_req(3'd7, '1, '1, 1'b1));
      send_request(make_req(ACT_LOOKUP, mac_a, '0, 1'b0));
      send_request(make_req(ACT_CLEAR,  '1,    '1, 1'b1));
      send_request(make_req(ACT_LOOKUP, '1,    '0, 1'b0));

      // Sender holds off until the table has answered everything.
      wait_drained();

      // Fill the table at full rate on both sides, mostly remote entries on one
      // port so that the following list gives a long train of responses.
      no_idle   = 1'b1;
      first_mac = rand_mac();
      send_request(make_req(ACT_INSERT, first_mac, port_pool[1], 1'b0));
      while (shadow.ent_count < DEPTH)
         send_request(make_req(ACT_INSERT, rand_mac(),
                               ($urandom_range(0, 4) == 0) ? 10'($urandom()) : port_pool[1],
                               $urandom_range(0, 5) == 0));
      no_idle = 1'b0;
      // Both refusals report full, the second because fullness wins over the
      // duplicate search.
      send_request(make_req(ACT_INSERT,   rand_mac(), port_pool[2], 1'b1));
      send_request(make_req(ACT_INSERT,   first_mac,  port_pool[1], 1'b0));
      send_request(make_req(ACT_LIST_PRT, '0,         port_pool[1], 1'b0));
      send_request(make_req(ACT_LOOKUP,   first_mac,  '0,           1'b0));
      wait_drained();
      send_request(make_req(ACT_CLEAR, '0, '0, 1'b0));

      // Random part: bursts of inserts drawn from small pools so that
      // duplicates and hits are common, queries against the same pools, the
      // odd clear, fully random transactions and some undefined actions.
      start_count = requests_sent;
      while (requests_sent < start_count + REQUEST_TARGET) begin
         roll = $urandom_range(0, 99);
         if (roll < 40) begin
            burst = $urandom_range(1, 6);
            repeat (burst)
               send_request(make_req(ACT_INSERT, mac_pool[$urandom_range(0, 7)],
                                     port_pool[$urandom_range(0, 3)],
                                     $urandom_range(0, 2) == 0));
         end else if (roll < 75) begin
            case ($urandom_range(0, 2))
               0: send_request(make_req(ACT_LOOKUP, mac_pool[$urandom_range(0, 7)],
                                        10'($urandom()), 1'($urandom())));
               1: send_request(make_req(ACT_LIST_PRT, rand_mac(),
                                        port_pool[$urandom_range(0, 3)], 1'($urandom())));
               default: send_request(make_req(ACT_LIST_MAC, mac_pool[$urandom_range(0, 7)],
                                              10'($urandom()), 1'($urandom())));
            endcase
         end else if (roll < 82) begin
            no_idle = ~no_idle;
         end else if (roll < 87) begin
            if ($urandom_range(0, 1) == 0) wait_drained();
            send_request(make_req(ACT_CLEAR, rand_mac(), 10'($urandom()), 1'($urandom())));
         end else if (roll < 95) begin
            send_request(make_req(3'($urandom_range(0, 4)), rand_mac(), 10'($urandom()),
                                  1'($urandom())));
         end else begin
            send_request(make_req(3'($urandom_range(5, 7)), rand_mac(), 10'($urandom()),
                                  1'($urandom())));
         end
      end
      no_idle = 1'b0;

      wait_drained();
      // Anything the block still sends now is an unexpected transaction.
      repeat (SETTLE_CYCLES) @(posedge clock);

      $display("Sent %0d request transactions (plus %0d undefined), checked %0d responses.",
               requests_sent, ignored_sent, shadow.checked);
      $display("Longest list had %0d matches; %0d inserts were refused on a full table.",
               shadow.longest_list, shadow.full_refusals);
      if (shadow.mismatches == 0 && shadow.due_rsp.size() == 0) begin
         $display("Verification passed");
      end else begin
         $display("%0d failures", shadow.mismatches + shadow.due_rsp.size());
         $display("Verification failed");
      end
      $finish;
   end

endmodule
